FILE: hdl/chd_pkg.sv
package chd_pkg;

  // status codes of the final result
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BIG = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // characters of the size line
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [23:0] decoded_length;
  } out_item_t;

  // classified item as it waits in the queue
  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_ws;
  } entry_t;

endpackage

FILE: hdl/chd_front.sv
module chd_front (
  input  chd_pkg::in_item_t item,
  output chd_pkg::entry_t   entry
);

  logic [7:0] b;
  assign b = item.body_byte;

  // character classification of one byte
  always_comb begin
    entry           = '0;
    entry.kind      = item.kind;
    entry.body_byte = b;
    entry.is_cr     = (b == chd_pkg::CH_CR);
    entry.is_lf     = (b == chd_pkg::CH_LF);
    entry.is_semi   = (b == chd_pkg::CH_SEMI);
    entry.is_ws     = (b == chd_pkg::CH_SPACE) || (b == chd_pkg::CH_TAB);
    if (b >= 8'h30 && b <= 8'h39) begin
      entry.is_hex  = 1'b1;
      entry.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      entry.is_hex  = 1'b1;
      entry.hex_val = b[3:0] + 4'd9;
    end
  end

endmodule

FILE: hdl/chd_queue.sv
module chd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chd_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output chd_pkg::entry_t head
);

  chd_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/chd_back.sv
module chd_back #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  chd_pkg::entry_t        head,
  output logic                   pop,
  input  logic [LENGTH_BITS-1:0] limit,
  output logic                   result_valid,
  input  logic                   result_stall,
  output chd_pkg::out_item_t     result_item
);

  localparam int LB = LENGTH_BITS;

  localparam logic [2:0] PH_LINE     = 3'd0;
  localparam logic [2:0] PH_LINE_BAD = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_AFTER    = 3'd3;
  localparam logic [2:0] PH_AFTER_CR = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  logic [2:0]    phase,        phase_next;
  logic [LB+3:0] size_accum,   size_accum_next;
  logic [LB-1:0] chunk_left,   chunk_left_next;
  logic [LB-1:0] out_count,    out_count_next;
  logic          line_cr_seen, line_cr_seen_next;
  logic          in_extension, in_extension_next;
  logic          size_over,    size_over_next;
  logic          digit_seen,   digit_seen_next;
  logic          chunk_too_big, chunk_too_big_next;

  logic               take;
  logic               emit;
  chd_pkg::out_item_t res;

  assign take = head_valid && (!result_valid || !result_stall);
  assign pop  = take;

  // parser step for the item at the queue head
  always_comb begin
    logic          line_go;
    logic          eff_cr;
    logic          bad;
    logic [LB+3:0] acc_n;
    logic [LB:0]   sum;
    logic [LB+23:0] len_wide;

    phase_next         = phase;
    size_accum_next    = size_accum;
    chunk_left_next    = chunk_left;
    out_count_next     = out_count;
    line_cr_seen_next  = line_cr_seen;
    in_extension_next  = in_extension;
    size_over_next     = size_over;
    digit_seen_next    = digit_seen;
    chunk_too_big_next = chunk_too_big;
    emit     = 1'b0;
    res      = '0;
    line_go  = 1'b0;
    eff_cr   = line_cr_seen;
    bad      = 1'b0;
    acc_n    = {size_accum[LB-1:0], head.hex_val};
    sum      = '0;
    len_wide = {{24{1'b0}}, out_count};

    if (take) begin
      if (head.kind == chd_pkg::KIND_END) begin
        // end of body: truncated unless a status went out
        if (phase != PH_DONE) begin
          emit       = 1'b1;
          res.out_kind = 1'b1;
          res.status = chd_pkg::ST_BAD;
        end
        phase_next         = PH_LINE;
        size_accum_next    = '0;
        chunk_left_next    = '0;
        out_count_next     = '0;
        line_cr_seen_next  = 1'b0;
        in_extension_next  = 1'b0;
        size_over_next     = 1'b0;
        digit_seen_next    = 1'b0;
        chunk_too_big_next = 1'b0;
      end else begin
        case (phase)
          PH_LINE, PH_LINE_BAD: begin
            line_go = 1'b1;
            bad     = (phase == PH_LINE_BAD);
          end
          PH_DATA: begin
            if (!chunk_too_big) begin
              emit          = 1'b1;
              res.data_byte = head.body_byte;
              out_count_next = out_count + 1'b1;
            end
            chunk_left_next = chunk_left - 1'b1;
            if (chunk_left_next == '0) begin
              if (chunk_too_big) begin
                chunk_too_big_next = 1'b0;
                emit         = 1'b1;
                res.out_kind = 1'b1;
                res.status   = chd_pkg::ST_BIG;
                phase_next   = PH_DONE;
              end else begin
                phase_next = PH_AFTER;
              end
            end
          end
          PH_AFTER: begin
            if (head.is_cr) begin
              phase_next = PH_AFTER_CR;
            end else begin
              line_go = 1'b1;
            end
          end
          PH_AFTER_CR: begin
            phase_next = PH_LINE;
            if (!head.is_lf) begin
              line_go = 1'b1;
              eff_cr  = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (line_go) begin
          if (eff_cr && head.is_lf) begin
            // line end: check and start the chunk
            size_accum_next   = '0;
            in_extension_next = 1'b0;
            size_over_next    = 1'b0;
            digit_seen_next   = 1'b0;
            line_cr_seen_next = 1'b0;
            if (size_over) begin
              emit = 1'b1;
              res.out_kind = 1'b1;
              res.status   = chd_pkg::ST_BIG;
              phase_next   = PH_DONE;
            end else if (bad || !digit_seen) begin
              emit = 1'b1;
              res.out_kind = 1'b1;
              res.status   = chd_pkg::ST_BAD;
              phase_next   = PH_DONE;
            end else if (size_accum == '0) begin
              emit = 1'b1;
              res.out_kind       = 1'b1;
              res.status         = chd_pkg::ST_OK;
              res.decoded_length = len_wide[23:0];
              phase_next         = PH_DONE;
            end else begin
              chunk_left_next    = size_accum[LB-1:0];
              sum                = {1'b0, out_count} + {1'b0, size_accum[LB-1:0]};
              chunk_too_big_next = (sum > {1'b0, limit});
              phase_next         = PH_DATA;
            end
          end else begin
            // a pending cr that was not a line end counts as a line byte
            if (eff_cr) begin
              if (!(bad || in_extension || size_over)) begin
                bad = 1'b1;
              end
              line_cr_seen_next = 1'b0;
            end
            if (head.is_cr) begin
              line_cr_seen_next = 1'b1;
            end else if (!(bad || in_extension || size_over)) begin
              if (head.is_hex) begin
                size_accum_next = acc_n;
                if (acc_n > {4'b0000, limit}) begin
                  size_over_next = 1'b1;
                end else begin
                  digit_seen_next = 1'b1;
                end
              end else if (head.is_semi) begin
                in_extension_next = 1'b1;
              end else if (!head.is_ws) begin
                bad = 1'b1;
              end
            end
            phase_next = bad ? PH_LINE_BAD : PH_LINE;
          end
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LINE;
      size_accum    <= '0;
      chunk_left    <= '0;
      out_count     <= '0;
      line_cr_seen  <= 1'b0;
      in_extension  <= 1'b0;
      size_over     <= 1'b0;
      digit_seen    <= 1'b0;
      chunk_too_big <= 1'b0;
    end else begin
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      chunk_left    <= chunk_left_next;
      out_count     <= out_count_next;
      line_cr_seen  <= line_cr_seen_next;
      in_extension  <= in_extension_next;
      size_over     <= size_over_next;
      digit_seen    <= digit_seen_next;
      chunk_too_big <= chunk_too_big_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_item <= res;
    end
  end

endmodule

FILE: hdl/http_chunked_body_decoder.sv
// a result item is captured by the output register when its item is accepted
// throughput: one item per cycle while result_stall does not hold the output, set by the back end's parser step
// a two-entry queue parts classification from parsing; the output register parts the sides
// reset (rst, synchronous): parser to start of a size line, queue and output emptied,
// body_limit back to 65536
module http_chunked_body_decoder #(
  parameter int LENGTH_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  chd_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output chd_pkg::out_item_t result_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);

  localparam int LB = LENGTH_BITS;

  logic [23:0]     body_limit;
  logic [LB+23:0]  lim_wide;
  logic [LB-1:0]   limit;
  chd_pkg::entry_t entry;
  chd_pkg::entry_t head;
  logic            q_full;
  logic            head_valid;
  logic            pop;
  logic            push;

  // limit register, saturated to the length width
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      body_limit <= cfg_data;
    end
  end

  assign lim_wide = {{LB{1'b0}}, body_limit};
  assign limit    = (lim_wide[LB+23:LB] != {24{1'b0}}) ? {LB{1'b1}} : lim_wide[LB-1:0];

  // front end
  assign byte_stall = q_full;
  assign push       = byte_valid && !byte_stall;

  chd_front u_front (
    .item  (byte_item),
    .entry (entry)
  );

  chd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end
  chd_back #(
    .LENGTH_BITS (LB)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .limit        (limit),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // status code is always one of the defined three
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.status == chd_pkg::ST_OK ||
                      result_item.status == chd_pkg::ST_BIG ||
                      result_item.status == chd_pkg::ST_BAD))
    else $error("undefined status code");

  // data items carry no status and no length
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.out_kind) |->
      (result_item.status == chd_pkg::ST_OK && result_item.decoded_length == 24'd0))
    else $error("data item with status fields set");

  // error status carries no length
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.out_kind && result_item.status != chd_pkg::ST_OK) |->
      (result_item.decoded_length == 24'd0 && result_item.data_byte == 8'd0))
    else $error("error status with length or data");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

FILE: verif/http_chunked_body_decoder_tb.sv
module http_chunked_body_decoder_tb;

  localparam logic OUT_DATA   = 1'b0;
  localparam logic OUT_STATUS = 1'b1;
  // output register plus the two-entry queue, with margin
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 600;

  typedef enum logic [2:0] {
    P_LINE, P_LINE_BAD, P_DATA, P_AFTER, P_AFTER_CR, P_DONE
  } parse_phase_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               byte_valid   = 1'b0;
  logic               byte_stall;
  chd_pkg::in_item_t  byte_item    = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  chd_pkg::out_item_t result_item;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [23:0]        cfg_data     = '0;

  http_chunked_body_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as the testbench tracks it
  logic [23:0]  limit_m;
  parse_phase_t phase_m;
  logic [31:0]  size_acc;
  logic [23:0]  chunk_rem;
  logic [23:0]  byte_total;
  bit           line_cr;
  bit           ext_on;
  bit           size_big;
  bit           digit_ok;
  bit           chunk_big;

  // result of the latest decode step
  bit                 step_has;
  chd_pkg::out_item_t step_out;

  chd_pkg::out_item_t pending_results[$];
  logic [7:0]         body_bytes[$];
  int                 mismatch_count = 0;
  int                 items_sent     = 0;
  bit                 gaps_on        = 1'b0;

  task automatic clear_parser();
    phase_m    = P_LINE;
    size_acc   = '0;
    chunk_rem  = '0;
    byte_total = '0;
    line_cr    = 1'b0;
    ext_on     = 1'b0;
    size_big   = 1'b0;
    digit_ok   = 1'b0;
    chunk_big  = 1'b0;
  endtask

  task automatic report_status(input logic [1:0] st, input logic [23:0] len);
    step_has                = 1'b1;
    step_out                = '0;
    step_out.out_kind       = OUT_STATUS;
    step_out.status         = st;
    step_out.decoded_length = len;
    phase_m                 = P_DONE;
  endtask

  // one character of a chunk-size line
  task automatic size_char(input logic [7:0] c);
    logic [3:0] digit;
    if (phase_m == P_LINE_BAD || ext_on || size_big) return;
    if (c >= "0" && c <= "9") begin
      digit = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      digit = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      digit = 4'(c - "A" + 8'd10);
    end else begin
      if (c == chd_pkg::CH_SEMI) ext_on = 1'b1;
      else if (c != chd_pkg::CH_SPACE && c != chd_pkg::CH_TAB) phase_m = P_LINE_BAD;
      return;
    end
    size_acc = size_acc * 16 + digit;
    if (size_acc > {8'b0, limit_m}) size_big = 1'b1;
    else digit_ok = 1'b1;
  endtask

  // CRLF closing a size line
  task automatic finish_line();
    logic [31:0] size;
    bit          over;
    bit          bad;
    size     = size_acc;
    over     = size_big;
    bad      = (phase_m == P_LINE_BAD) || !digit_ok;
    size_acc = '0;
    ext_on   = 1'b0;
    size_big = 1'b0;
    digit_ok = 1'b0;
    line_cr  = 1'b0;
    if (over) begin
      report_status(chd_pkg::ST_BIG, '0);
    end else if (bad) begin
      report_status(chd_pkg::ST_BAD, '0);
    end else if (size == 0) begin
      report_status(chd_pkg::ST_OK, byte_total);
    end else begin
      chunk_rem = size[23:0];
      chunk_big = ({8'b0, byte_total} + {8'b0, chunk_rem}) > {8'b0, limit_m};
      phase_m   = P_DATA;
    end
  endtask

  task automatic line_byte(input logic [7:0] b);
    if (line_cr && b == chd_pkg::CH_LF) begin
      finish_line();
    end else begin
      // a CR not followed by LF is an ordinary line character
      if (line_cr) begin
        size_char(chd_pkg::CH_CR);
        line_cr = 1'b0;
      end
      if (b == chd_pkg::CH_CR) line_cr = 1'b1;
      else size_char(b);
    end
  endtask

  // expected result of one accepted item
  task automatic decode_step(input chd_pkg::in_item_t it);
    logic [7:0] b;
    b        = it.body_byte;
    step_has = 1'b0;
    step_out = '0;
    if (it.kind == chd_pkg::KIND_END) begin
      if (phase_m != P_DONE) report_status(chd_pkg::ST_BAD, '0);
      clear_parser();
    end else begin
      case (phase_m)
        P_LINE, P_LINE_BAD: begin
          line_byte(b);
        end
        P_DATA: begin
          if (!chunk_big) begin
            step_has           = 1'b1;
            step_out.out_kind  = OUT_DATA;
            step_out.data_byte = b;
            byte_total         = byte_total + 1'b1;
          end
          chunk_rem = chunk_rem - 1'b1;
          if (chunk_rem == 0) begin
            if (chunk_big) begin
              chunk_big = 1'b0;
              report_status(chd_pkg::ST_BIG, '0);
            end else begin
              phase_m = P_AFTER;
            end
          end
        end
        P_AFTER: begin
          if (b == chd_pkg::CH_CR) begin
            phase_m = P_AFTER_CR;
          end else begin
            phase_m = P_LINE;
            line_byte(b);
          end
        end
        P_AFTER_CR: begin
          phase_m = P_LINE;
          if (b != chd_pkg::CH_LF) begin
            line_cr = 1'b1;
            line_byte(b);
          end
        end
        default: ;
      endcase
    end
  endtask

  // send one item, with random idle cycles ahead of it while gaps_on is set
  task automatic send_item(input chd_pkg::in_item_t it);
    while (gaps_on && $urandom_range(99) < 22) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_step(it);
    if (step_has) pending_results.push_back(step_out);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    chd_pkg::in_item_t it;
    it.kind      = chd_pkg::KIND_BYTE;
    it.body_byte = b;
    send_item(it);
  endtask

  task automatic send_end();
    chd_pkg::in_item_t it;
    it.kind      = chd_pkg::KIND_END;
    it.body_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic send_line(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(chd_pkg::CH_CR);
    send_byte(chd_pkg::CH_LF);
  endtask

  // stop sending until every expected result is out and the pipe is empty
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_m = value;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0:       return chd_pkg::CH_CR;
      1:       return chd_pkg::CH_LF;
      2:       return 8'("0" + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] pick_limit();
    case ($urandom_range(5))
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 20));
      2:       return 24'($urandom_range(21, 80));
      3:       return 24'h010000;
      4:       return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // size line with random case, padding and extension
  task automatic add_size_line(input int size);
    string      hex;
    int         i;
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      body_bytes.push_back($urandom_range(1) ? chd_pkg::CH_SPACE : chd_pkg::CH_TAB);
    end
    if ($urandom_range(4) == 0) body_bytes.push_back("0");
    hex = $sformatf("%0h", size);
    for (i = 0; i < hex.len(); i++) begin
      c = hex[i];
      if (c >= "a" && $urandom_range(1)) c = c - 8'd32;
      body_bytes.push_back(c);
    end
    if ($urandom_range(4) == 0) begin
      body_bytes.push_back($urandom_range(1) ? chd_pkg::CH_SPACE : chd_pkg::CH_TAB);
    end
    if ($urandom_range(4) == 0) begin
      body_bytes.push_back(chd_pkg::CH_SEMI);
      repeat ($urandom_range(0, 4)) body_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
    body_bytes.push_back(chd_pkg::CH_CR);
    body_bytes.push_back(chd_pkg::CH_LF);
  endtask

  // mostly well-formed bodies, some corrupted, truncated or pure noise
  task automatic build_random_body();
    int size;
    int keep;
    body_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 16)) body_bytes.push_back(noise_byte());
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      size = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_size_line(size);
      repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
      case ($urandom_range(5))
        0: ;
        1: body_bytes.push_back(chd_pkg::CH_CR);
        default: begin
          body_bytes.push_back(chd_pkg::CH_CR);
          body_bytes.push_back(chd_pkg::CH_LF);
        end
      endcase
    end
    add_size_line(0);
    // trailer bytes after the last chunk
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 6)) body_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(4) == 0) begin
      body_bytes[$urandom_range(0, body_bytes.size() - 1)] = noise_byte();
    end
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(0, body_bytes.size() - 1);
      while (body_bytes.size() > keep) void'(body_bytes.pop_back());
    end
  endtask

  task automatic test_basic_bodies();
    gaps_on = 1'b1;
    // two-byte chunk with extremes, optional CRLF, zero chunk, end after status
    send_byte(chd_pkg::CH_TAB);
    send_line("2;");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(chd_pkg::CH_CR);
    send_byte(chd_pkg::CH_LF);
    send_line("0");
    send_end();
    // empty size line
    send_byte(chd_pkg::CH_CR);
    send_byte(chd_pkg::CH_LF);
    send_end();
    // stray CR inside the size line
    send_byte("1");
    send_byte(chd_pkg::CH_CR);
    send_line("g");
    send_end();
    // CR after data without LF, then the body is cut short
    send_line("1");
    send_byte("a");
    send_byte(chd_pkg::CH_CR);
    send_byte("1");
    send_end();
  endtask

  task automatic test_size_limits();
    gaps_on = 1'b1;
    write_limit(24'd3);
    // size line over the limit
    send_line("4");
    send_end();
    // chunk would push the total past the limit
    send_line("2");
    send_byte("a");
    send_byte("b");
    send_line("3");
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_end();
    write_limit(24'd16);
    // junk first, then overflow
    send_line("1g1");
    send_end();
    // overflow first, then junk
    send_line("111g");
    send_end();
    write_limit(24'd0);
    send_line("0");
    send_end();
    send_line("1");
    send_end();
    write_limit(24'hFFFFFF);
    // truncated in the middle of a chunk
    send_line("FFFFFF");
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_end();
    send_line("1000000");
    send_end();
    write_limit(24'h010000);
  endtask

  task automatic test_random_bodies();
    int first;
    int bodies;
    int i;
    first  = items_sent;
    bodies = 0;
    // opening stretch with no idle cycles on either side
    gaps_on = 1'b0;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first > 200) gaps_on = 1'b1;
      if (bodies % 6 == 0) write_limit(pick_limit());
      else if (bodies % 6 == 3) wait_drained();
      build_random_body();
      for (i = 0; i < body_bytes.size(); i++) send_byte(body_bytes[i]);
      send_end();
      bodies++;
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver stall and result checking
  always @(posedge clk) begin : check_results
    chd_pkg::out_item_t want;
    result_stall <= gaps_on && ($urandom_range(99) < 22);
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_item);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", 24'(want.out_kind), 24'(result_item.out_kind));
        check_field("data_byte", 24'(want.data_byte), 24'(result_item.data_byte));
        check_field("status", 24'(want.status), 24'(result_item.status));
        check_field("decoded_length", want.decoded_length, result_item.decoded_length);
      end
    end
  end

  initial begin
    limit_m = 24'h010000;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_bodies();
    test_size_limits();
    test_random_bodies();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("http_chunked_body_decoder verification clean");
    end else begin
      $display("http_chunked_body_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("http_chunked_body_decoder verification failed");
    $finish;
  end

endmodule

FILE: http_chunked_body_decoder.f
hdl/chd_pkg.sv
hdl/chd_front.sv
hdl/chd_queue.sv
hdl/chd_back.sv
hdl/http_chunked_body_decoder.sv
verif/http_chunked_body_decoder_tb.sv
